// ----- src/mpsd_pkg.sv -----
// Package: shared types, constants and level tables of the motor pulse speed decoder.
`default_nettype none
package mpsd_pkg;

  localparam int unsigned TIME_W   = 32;
  localparam int unsigned GAP_W    = 20;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned LEVEL_W  = 4;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = GAP_W;
  localparam int unsigned OUT_TDATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_GAP_LIMIT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_SPEED = 1'd1;

  localparam logic [GAP_W-1:0]   GAP_LIMIT_RST  = 20'd15000;
  localparam logic [COUNT_W-1:0] FULL_SPEED_RST = 5'd14;
  localparam logic [COUNT_W-1:0] COUNT_MAX      = 5'd31;

  localparam logic [LEVEL_W-1:0] LEVEL_NONE        = 4'd0;
  localparam logic [LEVEL_W-1:0] LEVEL_MEDIUM_FULL = 4'd4;
  localparam logic [LEVEL_W-1:0] LEVEL_HIGH_FULL   = 4'd8;

  typedef struct packed {
    logic [TIME_W-1:0] event_time;
    logic              line_is_high;
  } edge_item_t;

  typedef struct packed {
    logic       valid;
    edge_item_t item;
  } queue_head_t;

  function automatic logic [LEVEL_W-1:0] medium_level(input logic [COUNT_W-1:0] n);
    logic [LEVEL_W-1:0] lvl;
    case (n)
      5'd5, 5'd6: lvl = 4'd1;
      5'd9:       lvl = 4'd2;
      5'd13:      lvl = 4'd3;
      default:    lvl = LEVEL_NONE;
    endcase
    return lvl;
  endfunction

  function automatic logic [LEVEL_W-1:0] high_level(input logic [COUNT_W-1:0] n);
    logic [LEVEL_W-1:0] lvl;
    case (n)
      5'd4:    lvl = 4'd5;
      5'd6:    lvl = 4'd6;
      5'd9:    lvl = 4'd7;
      default: lvl = LEVEL_NONE;
    endcase
    return lvl;
  endfunction

endpackage
`default_nettype wire

// ----- src/mpsd_queue.sv -----
// Two-entry queue that takes edge transactions in and hands them to the decoder.
`default_nettype none
module mpsd_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire mpsd_pkg::edge_item_t push_item,
  output logic                     not_full,
  input  wire logic                pop,
  output mpsd_pkg::queue_head_t    head
);
  import mpsd_pkg::*;

  edge_item_t  mem [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  count_r, count_nxt;
  logic        do_push, do_pop;

  assign not_full   = (count_r != 2'd2);
  assign do_push    = push && not_full;
  assign do_pop     = pop && (count_r != 2'd0);
  assign head.valid = (count_r != 2'd0);
  assign head.item  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

// ----- src/mpsd_core.sv -----
// Burst counter, gap check and level decoder with its output register.
`default_nettype none
module mpsd_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [mpsd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [mpsd_pkg::CFG_DATA_W-1:0] cfg_wr_data,
  input  wire mpsd_pkg::queue_head_t         head,
  output logic                               pop,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [mpsd_pkg::LEVEL_W-1:0]       out_level,
  output logic                               out_changed
);
  import mpsd_pkg::*;

  logic [GAP_W-1:0]   gap_limit_r;
  logic [COUNT_W-1:0] full_speed_r;
  logic [COUNT_W-1:0] burst_count_r, burst_count_nxt;
  logic [COUNT_W-1:0] prior_medium_r, prior_medium_nxt;
  logic [TIME_W-1:0]  prior_time_r, prior_time_nxt;
  logic [LEVEL_W-1:0] level_r, level_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [LEVEL_W-1:0] out_level_r;
  logic               out_changed_r, changed_nxt;

  logic [COUNT_W-1:0] count_inc;
  logic [TIME_W-1:0]  gap;
  logic               closed, ignored;
  logic [LEVEL_W-1:0] decoded;

  assign pop         = head.valid && (!out_valid_r || out_ready);
  assign out_valid   = out_valid_r;
  assign out_level   = out_level_r;
  assign out_changed = out_changed_r;

  always_comb begin
    count_inc = (burst_count_r == COUNT_MAX) ? COUNT_MAX : burst_count_r + 5'd1;
    gap       = head.item.event_time - prior_time_r;
    closed    = gap > {{(TIME_W-GAP_W){1'b0}}, gap_limit_r};
    ignored   = closed && !head.item.line_is_high && (prior_medium_r == count_inc);

    decoded          = LEVEL_NONE;
    burst_count_nxt  = count_inc;
    prior_medium_nxt = prior_medium_r;
    if (closed) begin
      if (!head.item.line_is_high) begin
        decoded          = medium_level(count_inc);
        prior_medium_nxt = count_inc;
      end else begin
        decoded = high_level(count_inc);
      end
      burst_count_nxt = '0;
    end else if (count_inc >= full_speed_r) begin
      decoded         = head.item.line_is_high ? LEVEL_HIGH_FULL : LEVEL_MEDIUM_FULL;
      burst_count_nxt = '0;
    end

    level_nxt      = level_r;
    changed_nxt    = 1'b0;
    prior_time_nxt = head.item.event_time;
    if (ignored) begin
      burst_count_nxt  = count_inc;
      prior_medium_nxt = prior_medium_r;
      prior_time_nxt   = prior_time_r;
    end else if ((decoded != LEVEL_NONE) && (decoded != level_r)) begin
      level_nxt   = decoded;
      changed_nxt = 1'b1;
    end

    out_valid_nxt = pop ? 1'b1 : (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_limit_r    <= GAP_LIMIT_RST;
      full_speed_r   <= FULL_SPEED_RST;
      burst_count_r  <= '0;
      prior_medium_r <= '0;
      prior_time_r   <= '0;
      level_r        <= LEVEL_NONE;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_wr_en && (cfg_index == REG_GAP_LIMIT)) begin
        gap_limit_r <= cfg_wr_data;
      end
      if (cfg_wr_en && (cfg_index == REG_FULL_SPEED)) begin
        full_speed_r <= cfg_wr_data[COUNT_W-1:0];
      end
      if (pop) begin
        burst_count_r  <= burst_count_nxt;
        prior_medium_r <= prior_medium_nxt;
        prior_time_r   <= prior_time_nxt;
        level_r        <= level_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_level_r   <= level_nxt;
      out_changed_r <= changed_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- src/motor_pulse_speed_decoder.sv -----
// Top level of the motor pulse speed decoder: edge queue, decoder and checks.
//
//  channel | direction | handshake        | contents
//  in_     | slave     | tvalid/tready    | tdata event_time, tuser line_is_high
//  out_    | master    | tvalid/tready    | tdata speed_level, tuser level_changed
//  cfg_    | write     | cfg_wr_en        | cfg_index, cfg_wr_data
//
// One transaction a cycle sustained while out_tready stays high; a taken edge is
// registered in the two-entry queue and its result in the decoder's output register.
// Decoder next state: a 32-bit subtract, a compare and a table, registered on pop.
// A stalled output holds the result; the queue keeps taking edges until full.
// Reset is synchronous; it clears state but not queue storage or output data regs.
`default_nettype none
module motor_pulse_speed_decoder (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [mpsd_pkg::TIME_W-1:0]      in_tdata,    // [31:0] event_time
  input  wire logic [0:0]                       in_tuser,    // [0] line_is_high
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [mpsd_pkg::OUT_TDATA_W-1:0]      out_tdata,   // [3:0] speed_level
  output logic [0:0]                            out_tuser,   // [0] level_changed
  input  wire logic                             cfg_wr_en,
  input  wire logic [mpsd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [mpsd_pkg::CFG_DATA_W-1:0]  cfg_wr_data
);
  import mpsd_pkg::*;

  edge_item_t         push_item;
  queue_head_t        head;
  logic               pop;
  logic [LEVEL_W-1:0] out_level;
  logic               out_changed;

  assign push_item.event_time   = in_tdata;
  assign push_item.line_is_high = in_tuser[0];

  mpsd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_tvalid),
    .push_item (push_item),
    .not_full  (in_tready),
    .pop       (pop),
    .head      (head)
  );

  mpsd_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_level   (out_level),
    .out_changed (out_changed)
  );

  assign out_tdata = {{(OUT_TDATA_W-LEVEL_W){1'b0}}, out_level};
  assign out_tuser = out_changed;

  a_changed_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[LEVEL_W-1:0] != LEVEL_NONE)
    else $error("level change reported with no level");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[LEVEL_W-1:0] <= LEVEL_HIGH_FULL)
    else $error("speed level out of range");

  a_pop_shows: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> out_tvalid)
    else $error("decoded edge produced no result");

  a_pop_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head.valid && (!out_tvalid || out_tready))
    else $error("decoder took an edge with no room for its result");

endmodule
`default_nettype wire
